// ===== hw/rtl/wsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, fixed widths and arithmetic helpers for the windowed STFT core.
// No dependencies; imported by windowed_stft_frames_core and the testbench.

package wsf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAIL,
        S_LOAD,
        S_BF,
        S_ORD,
        S_OSEND
    } t_state;

    localparam int SMP_W  = 16;
    localparam int DAT_W  = 21;
    localparam int CF_W   = 17;
    localparam int PROD_W = DAT_W + CF_W;
    localparam int HOP_W  = 6;
    localparam int FIDX_W = 16;
    localparam int BIN_W  = 5;
    localparam int RND_W  = 25;
    localparam int SUM_W  = 26;

    localparam logic [HOP_W-1:0] HOP_RST = 6'd16;

    // load sequence steps
    localparam logic [2:0] LD_READ  = 3'd0;
    localparam logic [2:0] LD_MUL   = 3'd1;
    localparam logic [2:0] LD_WRITE = 3'd2;

    // butterfly sequence steps
    localparam logic [2:0] BF_READ  = 3'd0;
    localparam logic [2:0] BF_M_RC  = 3'd1;
    localparam logic [2:0] BF_M_IS  = 3'd2;
    localparam logic [2:0] BF_M_IC  = 3'd3;
    localparam logic [2:0] BF_M_RS  = 3'd4;
    localparam logic [2:0] BF_T_IM  = 3'd5;
    localparam logic [2:0] BF_WR_A  = 3'd6;
    localparam logic [2:0] BF_WR_B  = 3'd7;

    localparam logic [63:0]        PI_Q30  = 64'd3373259426;
    localparam logic signed [63:0] HAM_A   = 64'sd579820585;
    localparam logic signed [63:0] HAM_B   = 64'sd493921239;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    // Taylor series of cos(x), x in Q30 within [0, pi/2], truncating steps
    function automatic logic signed [63:0] cos_poly(input logic [63:0] x, input logic neg);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = 64'd1073741824;
        sum  = ONE_Q30;
        term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
        return neg ? -sum : sum;
    endfunction

    // floor((v + 2^14) / 2^15)
    function automatic logic signed [RND_W-1:0] rnd15(input logic signed [39:0] v);
        logic signed [39:0] t;
        t = v + 40'sd16384;
        return t[39:15];
    endfunction

    function automatic logic signed [DAT_W-1:0] sat21(input logic signed [SUM_W-1:0] v);
        logic signed [DAT_W-1:0] r;
        if (v > 26'sd1048575) begin
            r = 21'sd1048575;
        end else if (v < -26'sd1048576) begin
            r = -21'sd1048576;
        end else begin
            r = v[DAT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/windowed_stft_frames_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming STFT core: sample ring, Hamming window, radix-2 DFT, bin output.
// Depends on wsf_pkg for types, widths and rounding/saturation helpers.

// Takes one signed 16-bit sample per word and, whenever a frame of FRAME_LEN
// samples starting at a multiple of the hop is complete, windows it, runs a
// decimation-in-time transform and sends bins 0..FRAME_LEN/2 as one word each.
// On a word with tlast set, a final zero-padded frame is sent if it starts
// before the end of the signal, and frame numbering restarts. Each frame is
// windowed into the work memory, transformed in (FRAME_LEN/2)*log2(FRAME_LEN)
// butterflies and then sent bin by bin, waiting on any output stall. All
// products go through one 21x17 multiplier and the work memory has one write
// port. The input is not ready while a frame is in progress. The hop register
// accepts a write only while the block is idle; a hop of 0 acts as 1.

module windowed_stft_frames_core #(
    parameter int FRAME_LEN = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write: hop
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic        s_axis_tlast,   // last_sample
    // output words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [15:0] frame_index, [20:16] bin_index,
                                             // [41:21] real_part, [62:42] imag_part
    output logic [1:0]       m_axis_tuser,   // [0] padded_frame, [1] last_of_frame
    output logic             m_axis_tlast    // last_of_run
);
    import wsf_pkg::*;

    localparam int LOG     = $clog2(FRAME_LEN);
    localparam int HALF    = FRAME_LEN / 2;
    localparam int SW      = $clog2(LOG);
    localparam int WIN_DEN = FRAME_LEN - 1;
    localparam int DIST_W  = 7;

    localparam logic signed [DIST_W-1:0] DIST_N    = DIST_W'(FRAME_LEN);
    localparam logic [LOG:0]             AVAIL_N   = (LOG+1)'(FRAME_LEN);
    localparam logic [LOG-1:0]           IDX_LAST  = LOG'(FRAME_LEN - 1);
    localparam logic [LOG-1:0]           IDX_HALF  = LOG'(HALF);
    localparam logic [LOG-2:0]           BF_LAST   = (LOG-1)'(HALF - 1);
    localparam logic [SW-1:0]            STG_LAST  = SW'(LOG - 1);

    // ---------------- constant tables ----------------
    function automatic logic signed [63:0] cos_tw(input int unsigned m_in);
        int unsigned m;
        logic        neg;
        logic [63:0] x;
        m   = m_in % (2 * FRAME_LEN);
        neg = 1'b0;
        if (m > FRAME_LEN) m = 2 * FRAME_LEN - m;
        if (2 * m > FRAME_LEN) begin
            m   = FRAME_LEN - m;
            neg = 1'b1;
        end
        x = (PI_Q30 * 64'(m)) / FRAME_LEN;
        return cos_poly(x, neg);
    endfunction

    function automatic logic signed [63:0] cos_win(input int unsigned m_in);
        int unsigned m;
        logic        neg;
        logic [63:0] x;
        m   = m_in;
        neg = 1'b0;
        if (m >= 2 * WIN_DEN) m = m - 2 * WIN_DEN;
        if (m > WIN_DEN) m = 2 * WIN_DEN - m;
        if (2 * m > WIN_DEN) begin
            m   = WIN_DEN - m;
            neg = 1'b1;
        end
        x = (PI_Q30 * 64'(m)) / WIN_DEN;
        return cos_poly(x, neg);
    endfunction

    function automatic logic [15:0] win_q15(input int unsigned i);
        logic signed [63:0] c;
        logic signed [63:0] w;
        logic signed [63:0] q;
        c = cos_win(2 * i);
        w = HAM_A * ONE_Q30 - HAM_B * c;
        q = (w + 64'sd17592186044416) >>> 45;
        return (q > 64'sd32767) ? 16'd32767 : q[15:0];
    endfunction

    function automatic logic signed [CF_W-1:0] q15_of(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd16384) >>> 15;
        return t[CF_W-1:0];
    endfunction

    function automatic logic [LOG-1:0] bit_rev(input logic [LOG-1:0] v);
        logic [LOG-1:0] r;
        for (int b = 0; b < LOG; b++) r[b] = v[LOG-1-b];
        return r;
    endfunction

    logic [15:0]            w_rom [FRAME_LEN];
    logic signed [CF_W-1:0] tw_c  [HALF];
    logic signed [CF_W-1:0] tw_s  [HALF];

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_win
        localparam logic [15:0] W = win_q15(g);
        assign w_rom[g] = W;
    end

    for (genvar g = 0; g < HALF; g++) begin : g_tw
        localparam logic signed [CF_W-1:0] C = q15_of(cos_tw(2 * g));
        localparam logic signed [CF_W-1:0] S = q15_of(cos_tw(2 * g + 2 * FRAME_LEN - HALF));
        assign tw_c[g] = C;
        assign tw_s[g] = S;
    end

    // ---------------- registers ----------------
    t_state                    r_state, n_state;
    logic [HOP_W-1:0]          r_hop;
    logic [LOG-1:0]            r_wr_ptr, n_wr_ptr;
    logic signed [DIST_W-1:0]  r_dist, n_dist;
    logic [FIDX_W-1:0]         r_fc, n_fc;
    logic                      r_last, n_last;
    logic                      r_pad, n_pad;
    logic                      r_final, n_final;
    logic [LOG:0]              r_avail, n_avail;
    logic [LOG-1:0]            r_start, n_start;
    logic [LOG-1:0]            r_idx, n_idx;
    logic [2:0]                r_step, n_step;
    logic [SW-1:0]             r_stg, n_stg;
    logic [LOG-2:0]            r_bf, n_bf;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [PROD_W-1:0]  r_acc, n_acc;
    logic signed [RND_W-1:0]   r_tr, n_tr;
    logic signed [RND_W-1:0]   r_ti, n_ti;

    // memories and their registered read data
    logic [SMP_W-1:0]          r_ring [FRAME_LEN];
    logic [2*DAT_W-1:0]        r_work [FRAME_LEN];
    logic [SMP_W-1:0]          r_ring_q;
    logic [2*DAT_W-1:0]        r_qa, r_qb;

    logic                      in_acc, out_acc;
    logic [LOG-1:0]            ring_raddr;
    logic [LOG-1:0]            raddr_a, raddr_b;
    logic                      work_we;
    logic [LOG-1:0]            work_waddr;
    logic [2*DAT_W-1:0]        work_wdata;
    logic signed [DAT_W-1:0]   mul_a;
    logic signed [CF_W-1:0]    mul_b;
    logic [HOP_W-1:0]          hop_eff;
    logic signed [DIST_W-1:0]  dist_hop;

    // butterfly addressing
    logic [LOG-1:0]            bf_n, bf_h, bf_j, bf_a, bf_b, bf_k;
    logic signed [CF_W-1:0]    tw_cos, tw_sin;
    logic signed [DAT_W-1:0]   ar, ai, br, bi;
    logic signed [RND_W-1:0]   win_smp;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign hop_eff = (r_hop == '0) ? HOP_W'(1) : r_hop;
    assign dist_hop = r_dist - $signed({1'b0, hop_eff});

    assign bf_n   = LOG'(r_bf);
    assign bf_h   = LOG'(1) << r_stg;
    assign bf_j   = bf_n & (bf_h - LOG'(1));
    assign bf_a   = ((bf_n >> r_stg) << (r_stg + 1'b1)) | bf_j;
    assign bf_b   = bf_a | bf_h;
    assign bf_k   = bf_j << (STG_LAST - r_stg);
    assign tw_cos = tw_c[bf_k[LOG-2:0]];
    assign tw_sin = tw_s[bf_k[LOG-2:0]];

    assign ar = r_qa[DAT_W-1:0];
    assign ai = r_qa[2*DAT_W-1:DAT_W];
    assign br = r_qb[DAT_W-1:0];
    assign bi = r_qb[2*DAT_W-1:DAT_W];

    assign win_smp    = rnd15(40'(r_prod));
    assign ring_raddr = r_start + r_idx;
    assign n_prod     = mul_a * mul_b;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_wr_ptr   = r_wr_ptr;
        n_dist     = r_dist;
        n_fc       = r_fc;
        n_last     = r_last;
        n_pad      = r_pad;
        n_final    = r_final;
        n_avail    = r_avail;
        n_start    = r_start;
        n_idx      = r_idx;
        n_step     = r_step;
        n_stg      = r_stg;
        n_bf       = r_bf;
        n_acc      = r_acc;
        n_tr       = r_tr;
        n_ti       = r_ti;
        work_we    = 1'b0;
        work_waddr = bf_a;
        work_wdata = '0;
        raddr_a    = bf_a;
        raddr_b    = bf_b;
        mul_a      = br;
        mul_b      = tw_cos;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_wr_ptr = r_wr_ptr + 1'b1;
                    n_dist   = r_dist + 1'b1;
                    n_last   = s_axis_tlast;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx  = '0;
                n_step = LD_READ;
                if (r_dist == DIST_N) begin
                    // full frame starts where the next write goes
                    n_avail = AVAIL_N;
                    n_pad   = 1'b0;
                    n_start = r_wr_ptr;
                    n_dist  = dist_hop;
                    n_final = !(r_last && (dist_hop > 0));
                    n_state = S_LOAD;
                end else if (r_last) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                n_idx  = '0;
                n_step = LD_READ;
                if (r_dist > 0) begin
                    n_avail = r_dist[LOG:0];
                    n_pad   = 1'b1;
                    n_start = r_wr_ptr - r_dist[LOG-1:0];
                    n_final = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_wr_ptr = '0;
                    n_dist   = '0;
                    n_fc     = '0;
                    n_last   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_LOAD: begin
                mul_a = DAT_W'($signed(r_ring_q));
                mul_b = $signed({1'b0, w_rom[r_idx]});
                unique case (r_step)
                    LD_READ: n_step = LD_MUL;
                    LD_MUL:  n_step = LD_WRITE;
                    default: begin
                        // zero past the received samples; bit-reversed store
                        work_we    = 1'b1;
                        work_waddr = bit_rev(r_idx);
                        work_wdata = {{DAT_W{1'b0}},
                                      ({1'b0, r_idx} < r_avail) ? win_smp[DAT_W-1:0]
                                                                 : {DAT_W{1'b0}}};
                        n_step = LD_READ;
                        if (r_idx == IDX_LAST) begin
                            n_stg   = '0;
                            n_bf    = '0;
                            n_state = S_BF;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                endcase
            end
            S_BF: begin
                n_step = r_step + 1'b1;
                unique case (r_step)
                    BF_READ: ;
                    BF_M_RC: begin
                        mul_a = br;
                        mul_b = tw_cos;
                    end
                    BF_M_IS: begin
                        mul_a = bi;
                        mul_b = tw_sin;
                        n_acc = r_prod;
                    end
                    BF_M_IC: begin
                        mul_a = bi;
                        mul_b = tw_cos;
                        n_tr  = rnd15(40'(r_acc) + 40'(r_prod));
                    end
                    BF_M_RS: begin
                        mul_a = br;
                        mul_b = tw_sin;
                        n_acc = r_prod;
                    end
                    BF_T_IM: begin
                        n_ti = rnd15(40'(r_acc) - 40'(r_prod));
                    end
                    BF_WR_A: begin
                        work_we    = 1'b1;
                        work_waddr = bf_a;
                        work_wdata = {sat21(SUM_W'(ai) + SUM_W'(r_ti)),
                                      sat21(SUM_W'(ar) + SUM_W'(r_tr))};
                    end
                    default: begin
                        work_we    = 1'b1;
                        work_waddr = bf_b;
                        work_wdata = {sat21(SUM_W'(ai) - SUM_W'(r_ti)),
                                      sat21(SUM_W'(ar) - SUM_W'(r_tr))};
                        if (r_bf == BF_LAST) begin
                            n_bf = '0;
                            if (r_stg == STG_LAST) begin
                                n_idx   = '0;
                                n_state = S_ORD;
                            end else begin
                                n_stg = r_stg + 1'b1;
                            end
                        end else begin
                            n_bf = r_bf + 1'b1;
                        end
                    end
                endcase
            end
            S_ORD: begin
                raddr_a = r_idx;
                n_state = S_OSEND;
            end
            S_OSEND: begin
                raddr_a = r_idx;
                if (out_acc) begin
                    if (r_idx == IDX_HALF) begin
                        n_fc = r_fc + 1'b1;
                        if (r_pad) begin
                            // signal ended: restart positions and numbering
                            n_wr_ptr = '0;
                            n_dist   = '0;
                            n_fc     = '0;
                            n_last   = 1'b0;
                            n_state  = S_IDLE;
                        end else if (r_last) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hop    <= HOP_RST;
            r_wr_ptr <= '0;
            r_dist   <= '0;
            r_fc     <= '0;
            r_last   <= 1'b0;
            r_idx    <= '0;
            r_step   <= '0;
            r_stg    <= '0;
            r_bf     <= '0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hop <= i_cfg_data;
            end
            r_wr_ptr <= n_wr_ptr;
            r_dist   <= n_dist;
            r_fc     <= n_fc;
            r_last   <= n_last;
            r_idx    <= n_idx;
            r_step   <= n_step;
            r_stg    <= n_stg;
            r_bf     <= n_bf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad   <= n_pad;
        r_final <= n_final;
        r_avail <= n_avail;
        r_start <= n_start;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_tr    <= n_tr;
        r_ti    <= n_ti;
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ring[r_wr_ptr] <= s_axis_tdata;
        end
        r_ring_q <= r_ring[ring_raddr];
    end

    // work memory: {imag, real}
    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work[work_waddr] <= work_wdata;
        end
        r_qa <= r_work[raddr_a];
        r_qb <= r_work[raddr_b];
    end

    // ---------------- ports ----------------
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OSEND);
    assign m_axis_tdata  = {1'b0, r_qa[2*DAT_W-1:DAT_W], r_qa[DAT_W-1:0],
                            BIN_W'(r_idx), r_fc};
    assign m_axis_tuser  = {(r_idx == IDX_HALF), r_pad};
    assign m_axis_tlast  = (r_idx == IDX_HALF) && r_final;

    // ---------------- assertions ----------------
    a_busy_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a bin is pending");

    a_run_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
        else $error("last_of_run away from the last bin of a frame");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= DIST_N)
        else $error("frame distance beyond frame length");

    a_accept_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK))
        else $error("accepted word not checked for a frame");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for windowed_stft_frames_core: Hamming window, 32-point DFT, bins 0..16.
// Depends on wsf_pkg and the core; a built-in bin predictor checks every output word.

module testbench;
    import wsf_pkg::*;

    localparam int NPT    = 32;
    localparam int NHALF  = NPT / 2;
    localparam int DRAIN  = 900;

    typedef struct {
        logic [15:0]        frame;
        logic [4:0]         bin;
        logic signed [20:0] re;
        logic signed [20:0] im;
        logic               padded;
        logic               lof;
        logic               lor;
    } bin_word_t;

    typedef struct {
        int   value;
        int   reps;
        bit   alternate;
        bit   ends_signal;
        bit   zero_frame;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [5:0]         i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    windowed_stft_frames_core #(.FRAME_LEN(NPT)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    bin_word_t   pending_bins[$];
    logic [15:0] ring[NPT];
    int unsigned samples_in;
    int unsigned frame_start;
    logic [15:0] frame_num;
    logic [5:0]  hop_reg = HOP_RST;

    int errors = 0;
    int bins_seen = 0;
    int samples_sent = 0;
    int frames_padded = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // cos(pi*m/d) in Q30, truncating Taylor series on the folded angle
    function automatic longint cos_fix(int unsigned m, int unsigned d);
        longint unsigned x, x2, term;
        longint          acc;
        bit              neg;
        neg = 1'b0;
        m = m % (2 * d);
        if (m > d) m = 2 * d - m;
        if (2 * m > d) begin
            m = d - m;
            neg = 1'b1;
        end
        x    = 64'd3373259426 * 64'(m) / 64'(d);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        return neg ? -acc : acc;
    endfunction

    function automatic longint round_q15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clip21(longint v);
        if (v > 64'sd1048575) return 64'sd1048575;
        if (v < -64'sd1048576) return -64'sd1048576;
        return v;
    endfunction

    function automatic longint hamming_q15(int unsigned i);
        longint          w;
        longint unsigned q;
        w = 64'sd579820585 * (64'sd1 << 30) - 64'sd493921239 * cos_fix(2 * i, NPT - 1);
        q = (longint'(w) + (64'sd1 << 44)) >> 45;
        return (q > 32767) ? 64'sd32767 : longint'(q);
    endfunction

    // window, transform and queue the bins of the frame at frame_start
    function automatic void push_frame_bins(int unsigned avail, bit padded);
        longint      wr[NPT];
        longint      wi[NPT];
        longint      c, s, tr, ti, ar, ai, br, bi;
        int unsigned r, k, a, b;
        bin_word_t   bw;
        for (int i = 0; i < NPT; i++) begin
            r = 0;
            for (int t = 0; t < 5; t++) r = (r << 1) | ((i >> t) & 1);
            wr[r] = 0;
            wi[r] = 0;
            if (i < avail)
                wr[r] = round_q15(longint'($signed(ring[(frame_start + i) % NPT]))
                                  * hamming_q15(i));
        end
        for (int h = 1; h < NPT; h = h * 2) begin
            for (int st = 0; st < NPT; st += 2 * h) begin
                for (int j = 0; j < h; j++) begin
                    k  = j * (NPT / (2 * h));
                    c  = round_q15(cos_fix(2 * k, NPT));
                    s  = round_q15(cos_fix(2 * k + 2 * NPT - NHALF, NPT));
                    a  = st + j;
                    b  = st + j + h;
                    ar = wr[a]; ai = wi[a];
                    br = wr[b]; bi = wi[b];
                    tr = round_q15(br * c + bi * s);
                    ti = round_q15(bi * c - br * s);
                    wr[a] = clip21(ar + tr);
                    wi[a] = clip21(ai + ti);
                    wr[b] = clip21(ar - tr);
                    wi[b] = clip21(ai - ti);
                end
            end
        end
        for (int i = 0; i <= NHALF; i++) begin
            bw.frame  = frame_num;
            bw.bin    = 5'(i);
            bw.re     = 21'(wr[i]);
            bw.im     = 21'(wi[i]);
            bw.padded = padded;
            bw.lof    = (i == NHALF);
            bw.lor    = 1'b0;
            pending_bins.insert(pending_bins.size(), bw);
        end
        frame_num = frame_num + 16'd1;
    endfunction

    // update the predictor with one accepted sample; returns bins queued
    function automatic int predict_sample(logic [15:0] smp, bit last);
        int unsigned hop, d;
        int          n;
        hop = (hop_reg == 0) ? 1 : hop_reg;
        n = 0;
        ring[samples_in % NPT] = smp;
        samples_in++;
        if (samples_in - frame_start == NPT) begin
            push_frame_bins(NPT, 1'b0);
            n += NHALF + 1;
            frame_start += hop;
        end
        if (last) begin
            d = samples_in - frame_start;
            if (d > 0 && d <= NPT) begin
                push_frame_bins(d, 1'b1);
                n += NHALF + 1;
                frames_padded++;
            end
            samples_in = 0;
            frame_start = 0;
            frame_num = '0;
        end
        if (n > 0) pending_bins[$].lor = 1'b1;
        return n;
    endfunction

    // valid stays high after the accept; the next word or an idle gap replaces it
    task automatic send_sample(logic [15:0] smp, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        void'(predict_sample(smp, last));
        samples_sent++;
    endtask

    task automatic write_hop(logic [5:0] hop);
        s_axis_tvalid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hop;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hop_reg = hop;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            errors++;
        end
    endtask

    // output side: check accepted words, throttle tready
    always @(posedge i_clk) begin
        bin_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bins_seen++;
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $realtime,
                         m_axis_tdata);
                errors++;
            end else begin
                want = pending_bins.pop_front();
                check_field("frame_index", want.frame, m_axis_tdata[15:0]);
                check_field("bin_index", want.bin, m_axis_tdata[20:16]);
                check_field("real_part", want.re, $signed(m_axis_tdata[41:21]));
                check_field("imag_part", want.im, $signed(m_axis_tdata[62:42]));
                check_field("padded_frame", want.padded, m_axis_tuser[0]);
                check_field("last_of_frame", want.lof, m_axis_tuser[1]);
                check_field("last_of_run", want.lor, m_axis_tlast);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #100ms;
        $display("testbench: FAIL");
        $finish;
    end

    stim_row_t rows[] = '{
        '{0,      1,  1'b0, 1'b1, 1'b1},  // lone zero sample ends a signal
        '{-32768, 16, 1'b0, 1'b0, 1'b0},
        '{32767,  16, 1'b0, 1'b0, 1'b0},  // completes frame 0
        '{32767,  10, 1'b0, 1'b1, 1'b0},  // padded tail of 26 samples
        '{0,      32, 1'b0, 1'b1, 1'b1},  // silent frame, then silent padded tail
        '{-32768, 32, 1'b1, 1'b0, 1'b0},  // alternating extremes, top bin
        '{1,      3,  1'b0, 1'b0, 1'b0},
        '{-1,     13, 1'b0, 1'b1, 1'b0},
        '{12345,  1,  1'b0, 1'b1, 1'b0}
    };

    initial begin
        logic [5:0]  hops[6] = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd5, 6'd16};
        logic [15:0] smp;
        int          budget, len, n;
        bin_word_t   zb;

        samples_in = 0;
        frame_start = 0;
        frame_num = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 36;
        recv_stall_pct = 75;
        foreach (rows[r]) begin
            for (int i = 0; i < rows[r].reps; i++) begin
                smp = 16'(rows[r].value);
                if (rows[r].alternate && i % 2 == 1) smp = 16'sd32767;
                if (rows[r].zero_frame && rows[r].ends_signal && i == rows[r].reps - 1
                    && samples_in < NPT - 1) begin
                    // all-zero padded frame: every bin is zero
                    send_sample(smp, 1'b1);
                    n = pending_bins.size();
                    for (int q = n - NHALF - 1; q < n; q++) begin
                        zb = pending_bins[q];
                        if (zb.re != 0 || zb.im != 0 || !zb.padded) begin
                            $display("%0t: zero frame predicted wrong, expected 0, got %0d",
                                     $realtime, zb.re);
                            errors++;
                        end
                        pending_bins[q].re = '0;
                        pending_bins[q].im = '0;
                    end
                end else begin
                    send_sample(smp, rows[r].ends_signal && i == rows[r].reps - 1);
                end
            end
        end

        foreach (hops[p]) begin
            write_hop(hops[p]);
            if (p < 2) begin
                send_idle_pct = 36; recv_stall_pct = 75;
            end else if (p < 4) begin
                send_idle_pct = 75; recv_stall_pct = 36;
            end else begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            budget = 24;
            while (budget > 0) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 70);
                for (int i = 0; i < len && budget > 0; i++) begin
                    case ($urandom_range(9))
                        0: smp = 16'h8000;
                        1: smp = 16'h7fff;
                        2: smp = 16'h0000;
                        default: smp = 16'($urandom);
                    endcase
                    send_sample(smp, i == len - 1 || budget == 1);
                    budget--;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Run covered %0d samples and %0d bins, %0d padded frames, hops 0..63.",
                 samples_sent, bins_seen, frames_padded);
        if (errors == 0 && pending_bins.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
